### design/epm_pkg.sv
package epm_pkg;

  localparam int POOL_ENTRIES = 1024;
  localparam int RECEIVERS    = 32;
  localparam int PARAM_BITS   = 32;

  localparam int AW   = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int LW   = AW + 1;
  localparam int RW   = (RECEIVERS > 1) ? $clog2(RECEIVERS) : 1;
  localparam int PB   = (PARAM_BITS < 32) ? PARAM_BITS : 32;
  localparam int DW   = 6 + 8 + PB;

  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);

  localparam logic [2:0] K_SET      = 3'd0;
  localparam logic [2:0] K_POST     = 3'd1;
  localparam logic [2:0] K_BCAST    = 3'd2;
  localparam logic [2:0] K_POP      = 3'd3;
  localparam logic [2:0] K_FREE     = 3'd4;
  localparam logic [2:0] K_FREE_ALL = 3'd5;

  localparam logic [2:0] ST_QUEUED  = 3'd0;
  localparam logic [2:0] ST_DIRECT  = 3'd1;
  localparam logic [2:0] ST_POOL_MT = 3'd2;
  localparam logic [2:0] ST_POPPED  = 3'd3;
  localparam logic [2:0] ST_LIST_MT = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  receiver;
    logic [5:0]  sender;
    logic [7:0]  event_code;
    logic [31:0] event_param;
    logic        match_any;
    logic [7:0]  target_type;
    logic [9:0]  entry;
    logic        set_active;
    logic        set_direct;
  } item_t;

  typedef struct packed {
    logic [4:0]  about_receiver;
    logic [2:0]  status;
    logic [9:0]  entry_index;
    logic [5:0]  out_sender;
    logic [7:0]  out_event;
    logic [31:0] out_param;
    logic        last;
  } result_t;

  typedef struct packed {
    logic init_wr;
    logic cap;
    logic set_attr;
    logic free_one;
    logic scan_next;
    logic rd_free;
    logic q_commit;
    logic stage_direct;
    logic stage_pool_mt;
    logic stage_list_mt;
    logic pop_rd;
    logic pop_commit;
    logic fa_rd;
    logic fa_commit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic       init_last;
    logic [2:0] kind;
    logic       rx_ok;
    logic       sel;
    logic       direct;
    logic       last_r;
    logic       free_null;
    logic       head_null;
    logic       fa_stop;
    logic       stage_ok;
    logic       out_free;
  } sts_t;

endpackage

### design/epm_in_if.sv
interface epm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [4:0]  receiver;
  logic [5:0]  sender;
  logic [7:0]  event_code;
  logic [31:0] event_param;
  logic        match_any;
  logic [7:0]  target_type;
  logic [9:0]  entry;
  logic        set_active;
  logic        set_direct;

  modport source (output valid, kind, receiver, sender, event_code, event_param,
                  match_any, target_type, entry, set_active, set_direct,
                  input ready);
  modport sink (input valid, kind, receiver, sender, event_code, event_param,
                match_any, target_type, entry, set_active, set_direct,
                output ready);
endinterface

### design/epm_out_if.sv
interface epm_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  about_receiver;
  logic [2:0]  status;
  logic [9:0]  entry_index;
  logic [5:0]  out_sender;
  logic [7:0]  out_event;
  logic [31:0] out_param;
  logic        last;

  modport source (output valid, about_receiver, status, entry_index, out_sender,
                  out_event, out_param, last, input ready);
  modport sink (input valid, about_receiver, status, entry_index, out_sender,
                out_event, out_param, last, output ready);
endinterface

### design/epm_ram.sv
module epm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/epm_ctrl.sv
module epm_ctrl
  import epm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DISP  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_QWR   = 9'b000010000,
    S_POPWR = 9'b000100000,
    S_FARD  = 9'b001000000,
    S_FAWR  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.kind)
          K_SET: begin
            cmd.set_attr = 1'b1;
            state_next   = S_FIN;
          end
          K_FREE: begin
            cmd.free_one = 1'b1;
            state_next   = S_FIN;
          end
          K_FREE_ALL: state_next = sts.rx_ok ? S_FARD : S_FIN;
          K_POST:     state_next = sts.rx_ok ? S_SCAN : S_FIN;
          K_BCAST:    state_next = S_SCAN;
          K_POP: begin
            if (!sts.rx_ok) begin
              state_next = S_FIN;
            end else if (sts.head_null) begin
              cmd.stage_list_mt = 1'b1;
              state_next        = S_FIN;
            end else begin
              cmd.pop_rd = 1'b1;
              state_next = S_POPWR;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_SCAN: begin
        if (!sts.sel) begin
          if (sts.last_r) state_next = S_FIN;
          else cmd.scan_next = 1'b1;
        end else if (sts.direct) begin
          if (sts.stage_ok) begin
            cmd.stage_direct = 1'b1;
            if (sts.last_r) state_next = S_FIN;
            else cmd.scan_next = 1'b1;
          end
        end else if (sts.free_null) begin
          if (sts.stage_ok) begin
            cmd.stage_pool_mt = 1'b1;
            state_next        = S_FIN;
          end
        end else begin
          cmd.rd_free = 1'b1;
          state_next  = S_QWR;
        end
      end
      S_QWR: begin
        if (sts.stage_ok) begin
          cmd.q_commit = 1'b1;
          if (sts.last_r) begin
            state_next = S_FIN;
          end else begin
            cmd.scan_next = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      S_POPWR: begin
        if (sts.stage_ok) begin
          cmd.pop_commit = 1'b1;
          state_next     = S_FIN;
        end
      end
      S_FARD: begin
        if (sts.fa_stop) begin
          state_next = S_FIN;
        end else begin
          cmd.fa_rd  = 1'b1;
          state_next = S_FAWR;
        end
      end
      S_FAWR: begin
        cmd.fa_commit = 1'b1;
        state_next    = S_FARD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

### design/epm_dp.sv
module epm_dp
  import epm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  cmd_t    cmd,
  output sts_t    sts,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res
);

  item_t         cap;
  logic [RW-1:0] cur;
  logic [AW-1:0] init_cnt;
  logic [LW-1:0] steps;
  logic [LW-1:0] free_head;
  logic [LW-1:0] heads [RECEIVERS];
  logic          attr_active [RECEIVERS];
  logic          attr_direct [RECEIVERS];
  logic [7:0]    attr_type [RECEIVERS];

  logic          pend_v;
  result_t       pend;

  logic          link_we;
  logic [AW-1:0] link_waddr;
  logic [LW-1:0] link_wdata;
  logic          link_re;
  logic [AW-1:0] link_raddr;
  logic [LW-1:0] link_rdata;
  logic [DW-1:0] data_rdata;

  logic [LW-1:0] head_cur;
  logic          rx_ok;
  logic          ent_ok;
  logic          stage;
  result_t       stage_res;
  result_t       done_res;
  result_t       fin_res;

  assign head_cur = heads[cur];
  assign rx_ok    = 32'(cap.receiver) < 32'(RECEIVERS);
  assign ent_ok   = 32'(cap.entry) < 32'(POOL_ENTRIES);

  epm_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  epm_ram #(.WIDTH(DW), .DEPTH(POOL_ENTRIES)) u_data (
    .clk   (clk),
    .we    (cmd.q_commit),
    .waddr (free_head[AW-1:0]),
    .wdata ({cap.sender, cap.event_code, cap.event_param[PB-1:0]}),
    .re    (cmd.pop_rd),
    .raddr (head_cur[AW-1:0]),
    .rdata (data_rdata)
  );

  always_comb begin
    link_we    = 1'b0;
    link_waddr = head_cur[AW-1:0];
    link_wdata = free_head;
    if (cmd.init_wr) begin
      link_we    = 1'b1;
      link_waddr = init_cnt;
      link_wdata = LW'(init_cnt) + LW'(1);
    end else if (cmd.q_commit) begin
      link_we    = 1'b1;
      link_waddr = free_head[AW-1:0];
      link_wdata = head_cur;
    end else if (cmd.pop_commit) begin
      link_we    = 1'b1;
      link_wdata = NULL_LINK;
    end else if (cmd.free_one) begin
      link_we    = ent_ok;
      link_waddr = AW'(cap.entry);
    end else if (cmd.fa_commit) begin
      link_we    = 1'b1;
    end
  end

  assign link_re    = cmd.rd_free | cmd.pop_rd | cmd.fa_rd;
  assign link_raddr = cmd.rd_free ? free_head[AW-1:0] : head_cur[AW-1:0];

  always_comb begin
    sts.init_last = (32'(init_cnt) == 32'(POOL_ENTRIES - 1));
    sts.kind      = cap.kind;
    sts.rx_ok     = rx_ok;
    sts.sel       = (cap.kind == K_POST) ||
                    (attr_active[cur] && (cap.match_any || attr_type[cur] == cap.target_type));
    sts.direct    = attr_direct[cur];
    sts.last_r    = (cap.kind == K_POST) || (32'(cur) == 32'(RECEIVERS - 1));
    sts.free_null = free_head >= NULL_LINK;
    sts.head_null = head_cur >= NULL_LINK;
    sts.fa_stop   = (head_cur >= NULL_LINK) || (steps == NULL_LINK);
    sts.out_free  = !out_valid || out_ready;
    sts.stage_ok  = !pend_v || !out_valid || out_ready;
  end

  always_comb begin
    stage_res                = '0;
    stage_res.about_receiver = 5'(cur);
    stage_res.status         = ST_DONE;
    if (cmd.stage_direct) begin
      stage_res.status     = ST_DIRECT;
      stage_res.out_sender = cap.sender;
      stage_res.out_event  = cap.event_code;
      stage_res.out_param  = 32'(cap.event_param[PB-1:0]);
    end else if (cmd.stage_pool_mt) begin
      stage_res.status = ST_POOL_MT;
    end else if (cmd.stage_list_mt) begin
      stage_res.status = ST_LIST_MT;
    end else if (cmd.q_commit) begin
      stage_res.status      = ST_QUEUED;
      stage_res.entry_index = 10'(free_head[AW-1:0]);
    end else if (cmd.pop_commit) begin
      stage_res.status      = ST_POPPED;
      stage_res.entry_index = 10'(head_cur[AW-1:0]);
      stage_res.out_sender  = data_rdata[DW-1 -: 6];
      stage_res.out_event   = data_rdata[PB+7 -: 8];
      stage_res.out_param   = 32'(data_rdata[PB-1:0]);
    end
  end

  assign stage = cmd.stage_direct | cmd.stage_pool_mt | cmd.stage_list_mt |
                 cmd.q_commit | cmd.pop_commit;

  always_comb begin
    done_res                = '0;
    done_res.about_receiver = (cap.kind == K_BCAST) ? 5'd0 : cap.receiver;
    done_res.status         = ST_DONE;
  end

  always_comb begin
    fin_res      = pend_v ? pend : done_res;
    fin_res.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cap <= item;
    end
    if (rst) begin
      init_cnt <= '0;
    end else if (cmd.init_wr) begin
      init_cnt <= init_cnt + AW'(1);
    end
    if (cmd.cap) begin
      steps <= '0;
      cur   <= (item.kind != K_BCAST && 32'(item.receiver) < 32'(RECEIVERS))
               ? RW'(item.receiver) : '0;
    end else begin
      if (cmd.scan_next) cur <= cur + RW'(1);
      if (cmd.fa_commit) steps <= steps + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      for (int i = 0; i < RECEIVERS; i++) begin
        heads[i]       <= NULL_LINK;
        attr_active[i] <= 1'b0;
        attr_direct[i] <= 1'b0;
        attr_type[i]   <= '0;
      end
    end else begin
      if (cmd.set_attr && rx_ok) begin
        attr_active[RW'(cap.receiver)] <= cap.set_active;
        attr_direct[RW'(cap.receiver)] <= cap.set_direct;
        attr_type[RW'(cap.receiver)]   <= cap.target_type;
      end
      if (cmd.q_commit) begin
        free_head  <= link_rdata;
        heads[cur] <= free_head;
      end
      if (cmd.pop_commit) begin
        heads[cur] <= link_rdata;
      end
      if (cmd.free_one && ent_ok) begin
        free_head <= LW'(cap.entry);
      end
      if (cmd.fa_commit) begin
        heads[cur] <= link_rdata;
        free_head  <= head_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((stage && pend_v) || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (stage) begin
        pend_v <= 1'b1;
      end else if (cmd.finish) begin
        pend_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage) begin
      pend <= stage_res;
      if (pend_v) begin
        res <= pend;
      end
    end else if (cmd.finish) begin
      res <= fin_res;
    end
  end

endmodule

### design/event_pool_multi_list_manager.sv
// channel  dir  payload
// req      in   kind receiver sender event_code event_param match_any target_type
//               entry set_active set_direct
// rsp      out  about_receiver status entry_index out_sender out_event out_param last
//
// one item at a time; set, free entry and pop of an empty list go from dispatch to finish,
// pop reads the entry then commits it, post scans then delivers direct or queues the entry
// broadcast scans the receivers in order from 0, with a queue write step per queued entry
// free all returns entries one at a time, reading then writing the link memory for each
// after reset an init pass chains all 1024 link memory entries; req.ready stays low
// a stalled rsp holds the block once the result register and stage are full
module event_pool_multi_list_manager
  import epm_pkg::*;
(
  input logic clk,
  input logic rst,
  epm_in_if.sink    req,
  epm_out_if.source rsp
);

  cmd_t    cmd;
  sts_t    sts;
  item_t   item;
  result_t res;
  logic    in_ready;
  logic    out_valid;

  assign item = '{kind: req.kind, receiver: req.receiver, sender: req.sender,
                  event_code: req.event_code, event_param: req.event_param,
                  match_any: req.match_any, target_type: req.target_type,
                  entry: req.entry, set_active: req.set_active,
                  set_direct: req.set_direct};

  epm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  epm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .res       (res)
  );

  assign req.ready          = in_ready;
  assign rsp.valid          = out_valid;
  assign rsp.about_receiver = res.about_receiver;
  assign rsp.status         = res.status;
  assign rsp.entry_index    = res.entry_index;
  assign rsp.out_sender     = res.out_sender;
  assign rsp.out_event      = res.out_event;
  assign rsp.out_param      = res.out_param;
  assign rsp.last           = res.last;

  a_stage_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.q_commit || cmd.pop_commit || cmd.stage_direct || cmd.stage_pool_mt ||
     cmd.stage_list_mt) |-> sts.stage_ok)
    else $error("result staged without room");

  a_finish_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("final result loaded over a pending transfer");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item taken while one is in work");

endmodule

### bench/epm_checker.sv
`timescale 1ns / 100ps
module epm_checker
  import epm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  epm_in_if    req,
  epm_out_if   rsp,
  output int   fail_count,
  output int   awaiting
);

  logic [10:0] free_head;
  logic [10:0] link_mem [POOL_ENTRIES];
  logic [5:0]  sender_mem [POOL_ENTRIES];
  logic [7:0]  event_mem [POOL_ENTRIES];
  logic [31:0] param_mem [POOL_ENTRIES];
  logic [10:0] list_head [RECEIVERS];
  logic [9:0]  rx_attr [RECEIVERS];

  result_t expected_results[$];

  initial begin
    fail_count = 0;
    awaiting   = 0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (fail_count < 30)
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void clear_pool();
    free_head = '0;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      link_mem[i] = 11'(i + 1);
    end
    for (int r = 0; r < RECEIVERS; r++) begin
      list_head[r] = NULL_LINK;
      rx_attr[r]   = '0;
    end
  endfunction

  function automatic void push_result(input logic [4:0] rx, input logic [2:0] st,
                                      input logic [9:0] idx, input logic [5:0] snd,
                                      input logic [7:0] ev, input logic [31:0] prm);
    result_t r;
    r.about_receiver = rx;
    r.status         = st;
    r.entry_index    = idx;
    r.out_sender     = snd;
    r.out_event      = ev;
    r.out_param      = prm;
    r.last           = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic bit deliver_event(input logic [4:0] rx, input logic [5:0] snd,
                                       input logic [7:0] ev, input logic [31:0] prm);
    logic [9:0] idx;
    if (rx_attr[rx][1]) begin
      push_result(rx, ST_DIRECT, '0, snd, ev, prm);
      return 1'b1;
    end
    if (free_head[10]) begin
      push_result(rx, ST_POOL_MT, '0, '0, '0, '0);
      return 1'b0;
    end
    idx            = free_head[9:0];
    free_head      = link_mem[idx];
    sender_mem[idx] = snd;
    event_mem[idx] = ev;
    param_mem[idx] = prm;
    link_mem[idx]  = list_head[rx];
    list_head[rx]  = {1'b0, idx};
    push_result(rx, ST_QUEUED, idx, '0, '0, '0);
    return 1'b1;
  endfunction

  function automatic void apply_request(input item_t it);
    int         before_n;
    int         steps;
    logic [9:0] idx;
    before_n = expected_results.size();
    case (it.kind)
      K_SET: begin
        rx_attr[it.receiver] = {it.target_type, it.set_direct, it.set_active};
        push_result(it.receiver, ST_DONE, '0, '0, '0, '0);
      end
      K_POST: begin
        void'(deliver_event(it.receiver, it.sender, it.event_code, it.event_param));
      end
      K_BCAST: begin
        for (int r = 0; r < RECEIVERS; r++) begin
          if (rx_attr[r][0] && (it.match_any || rx_attr[r][9:2] == it.target_type)) begin
            if (!deliver_event(5'(r), it.sender, it.event_code, it.event_param))
              break;
          end
        end
        if (expected_results.size() == before_n)
          push_result('0, ST_DONE, '0, '0, '0, '0);
      end
      K_POP: begin
        if (list_head[it.receiver][10]) begin
          push_result(it.receiver, ST_LIST_MT, '0, '0, '0, '0);
        end else begin
          idx = list_head[it.receiver][9:0];
          list_head[it.receiver] = link_mem[idx];
          link_mem[idx] = NULL_LINK;
          push_result(it.receiver, ST_POPPED, idx, sender_mem[idx], event_mem[idx],
                      param_mem[idx]);
        end
      end
      K_FREE: begin
        link_mem[it.entry] = free_head;
        free_head = {1'b0, it.entry};
        push_result(it.receiver, ST_DONE, '0, '0, '0, '0);
      end
      K_FREE_ALL: begin
        steps = 0;
        while (!list_head[it.receiver][10] && steps < POOL_ENTRIES) begin
          idx = list_head[it.receiver][9:0];
          list_head[it.receiver] = link_mem[idx];
          link_mem[idx] = free_head;
          free_head = {1'b0, idx};
          steps++;
        end
        push_result(it.receiver, ST_DONE, '0, '0, '0, '0);
      end
      default: push_result(it.receiver, ST_DONE, '0, '0, '0, '0);
    endcase
    expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    item_t   it;
    result_t got;
    result_t want;
    if (rst) begin
      clear_pool();
      expected_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        it.kind        = req.kind;
        it.receiver    = req.receiver;
        it.sender      = req.sender;
        it.event_code  = req.event_code;
        it.event_param = req.event_param;
        it.match_any   = req.match_any;
        it.target_type = req.target_type;
        it.entry       = req.entry;
        it.set_active  = req.set_active;
        it.set_direct  = req.set_direct;
        apply_request(it);
      end
      if (rsp.valid && rsp.ready) begin
        got.about_receiver = rsp.about_receiver;
        got.status         = rsp.status;
        got.entry_index    = rsp.entry_index;
        got.out_sender     = rsp.out_sender;
        got.out_event      = rsp.out_event;
        got.out_param      = rsp.out_param;
        got.last           = rsp.last;
        if (expected_results.size() == 0) begin
          report("unexpected result, status", 32'(got.status), '0);
        end else begin
          want = expected_results.pop_front();
          if (got.about_receiver !== want.about_receiver)
            report("about_receiver", 32'(got.about_receiver), 32'(want.about_receiver));
          if (got.status !== want.status)
            report("status", 32'(got.status), 32'(want.status));
          if (got.entry_index !== want.entry_index)
            report("entry_index", 32'(got.entry_index), 32'(want.entry_index));
          if (got.out_sender !== want.out_sender)
            report("out_sender", 32'(got.out_sender), 32'(want.out_sender));
          if (got.out_event !== want.out_event)
            report("out_event", 32'(got.out_event), 32'(want.out_event));
          if (got.out_param !== want.out_param)
            report("out_param", got.out_param, want.out_param);
          if (got.last !== want.last)
            report("last", 32'(got.last), 32'(want.last));
        end
      end
    end
    awaiting <= expected_results.size();
  end

endmodule

### bench/event_pool_multi_list_manager_tb.sv
`timescale 1ns / 100ps
module event_pool_multi_list_manager_tb;
  import epm_pkg::*;

  localparam int STALL_LIMIT = 12000;
  localparam int LONG_HOLD   = 500;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   awaiting;
  int   idle_cycles;
  bit   quiet;
  bit   hold_req;
  logic [9:0] spare_entries[$];

  epm_in_if  req_ch ();
  epm_out_if rsp_ch ();

  event_pool_multi_list_manager u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  epm_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .awaiting   (awaiting)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_POPPED)
      spare_entries.push_back(rsp_ch.entry_index);
  end

  // result side back-pressure
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && hold_req) begin
        hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  end

  task automatic send_item(input item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= it.kind;
    req_ch.receiver    <= it.receiver;
    req_ch.sender      <= it.sender;
    req_ch.event_code  <= it.event_code;
    req_ch.event_param <= it.event_param;
    req_ch.match_any   <= it.match_any;
    req_ch.target_type <= it.target_type;
    req_ch.entry       <= it.entry;
    req_ch.set_active  <= it.set_active;
    req_ch.set_direct  <= it.set_direct;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  function automatic item_t random_item(input logic [2:0] k);
    item_t it;
    it.kind        = k;
    it.receiver    = 5'($urandom);
    it.sender      = 6'($urandom);
    it.event_code  = 8'($urandom);
    it.event_param = $urandom;
    it.match_any   = 1'($urandom);
    it.target_type = 8'($urandom_range(0, 3));
    it.entry       = 10'($urandom);
    it.set_active  = 1'($urandom);
    it.set_direct  = 1'($urandom);
    return it;
  endfunction

  task automatic send_op(input logic [2:0] k, input logic [4:0] rx);
    item_t it;
    it = random_item(k);
    it.receiver = rx;
    send_item(it);
  endtask

  task automatic send_setup(input logic [4:0] rx, input bit act, input bit dir,
                            input logic [7:0] typ);
    item_t it;
    it = random_item(K_SET);
    it.receiver    = rx;
    it.set_active  = act;
    it.set_direct  = dir;
    it.target_type = typ;
    send_item(it);
  endtask

  task automatic send_event(input logic [2:0] k, input logic [4:0] rx, input bit any,
                            input logic [7:0] typ, input logic [5:0] snd,
                            input logic [7:0] ev, input logic [31:0] prm);
    item_t it;
    it = random_item(k);
    it.receiver    = rx;
    it.match_any   = any;
    it.target_type = typ;
    it.sender      = snd;
    it.event_code  = ev;
    it.event_param = prm;
    send_item(it);
  endtask

  task automatic send_free(input logic [9:0] idx);
    item_t it;
    it = random_item(K_FREE);
    it.entry = idx;
    send_item(it);
  endtask

  task automatic random_traffic(input int count);
    item_t it;
    int    pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        it = random_item(K_SET);
        if ($urandom_range(0, 3) != 0) it.set_active = 1'b1;
        if ($urandom_range(0, 2) != 0) it.set_direct = 1'b0;
        if ($urandom_range(0, 7) == 0) it.target_type = 8'($urandom);
      end else if (pick < 40) begin
        it = random_item(K_POST);
      end else if (pick < 58) begin
        it = random_item(K_BCAST);
        if ($urandom_range(0, 7) == 0) it.target_type = 8'($urandom);
      end else if (pick < 80) begin
        it = random_item(K_POP);
      end else if (pick < 92) begin
        it = random_item(K_FREE);
        if (spare_entries.size() != 0 && $urandom_range(0, 5) != 0)
          it.entry = spare_entries.pop_front();
      end else begin
        it = random_item(K_FREE_ALL);
      end
      send_item(it);
    end
  endtask

  initial begin
    rst                <= 1'b1;
    quiet              = 1'b0;
    hold_req           = 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.kind        <= K_SET;
    req_ch.receiver    <= '0;
    req_ch.sender      <= '0;
    req_ch.event_code  <= '0;
    req_ch.event_param <= '0;
    req_ch.match_any   <= 1'b0;
    req_ch.target_type <= '0;
    req_ch.entry       <= '0;
    req_ch.set_active  <= 1'b0;
    req_ch.set_direct  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole pool so every entry holds written data
    for (int r = 0; r < RECEIVERS; r++)
      send_setup(5'(r), 1'b1, 1'b0, 8'(r % 4));
    for (int b = 0; b <= POOL_ENTRIES / RECEIVERS; b++)
      send_event(K_BCAST, 5'($urandom), 1'b1, '0, 6'($urandom), 8'($urandom), $urandom);
    send_event(K_POST, 5'd5, 1'b0, '0, 6'h3f, 8'hff, 32'hffff_ffff);
    for (int r = 0; r < RECEIVERS; r++)
      send_op(K_FREE_ALL, 5'(r));

    // directed cases
    send_setup(5'd0, 1'b1, 1'b1, 8'hff);
    send_setup(5'd31, 1'b1, 1'b0, 8'h00);
    send_setup(5'd7, 1'b0, 1'b1, 8'h55);
    send_event(K_POST, 5'd0, 1'b0, '0, 6'h3f, 8'hff, 32'hffff_ffff);
    send_event(K_POST, 5'd7, 1'b0, '0, 6'h00, 8'h00, 32'h0000_0000);
    send_event(K_POST, 5'd31, 1'b0, '0, 6'h00, 8'h00, 32'h0000_0000);
    send_event(K_POST, 5'd30, 1'b0, '0, 6'h3f, 8'hff, 32'hffff_ffff);
    send_op(K_POP, 5'd31);
    send_op(K_POP, 5'd31);
    send_op(K_POP, 5'd30);
    send_event(K_BCAST, 5'd0, 1'b0, 8'hab, 6'h2a, 8'h5a, 32'h1234_5678);
    send_event(K_BCAST, 5'd0, 1'b0, 8'hff, 6'h15, 8'ha5, 32'h8765_4321);
    send_event(K_BCAST, 5'd0, 1'b1, 8'h00, 6'h01, 8'h80, 32'h8000_0001);
    send_free(10'd0);
    send_free(10'd0);
    send_free(10'd1023);
    send_event(K_POST, 5'd3, 1'b0, '0, 6'h11, 8'h22, 32'h3333_4444);
    send_free(10'd1023);
    send_op(K_POP, 5'd3);
    send_op(K_FREE_ALL, 5'd3);
    send_op(K_FREE_ALL, 5'd9);
    send_op(K_POP, 5'd9);
    drain_results();

    random_traffic(100);
    hold_req = 1'b1;
    random_traffic(40);
    drain_results();
    random_traffic(80);
    quiet = 1'b1;
    random_traffic(40);

    drain_results();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && awaiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
